>>> rtl/cht_pkg.sv
// ---------------------------------------------------------------------------
// cht_pkg
// Shared types, constants and helpers for the chained hash table engine.
// ---------------------------------------------------------------------------
package cht_pkg;

   localparam int BUCKETS  = 64;
   localparam int ENTRIES  = 64;
   localparam int BUCKET_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int LINK_W   = $clog2(ENTRIES + 1);
   localparam int QDEPTH   = 2;
   localparam int QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(ENTRIES);
   localparam logic [31:0] FNV_BASIS = 32'd2166136261;
   localparam logic [31:0] FNV_MULT  = 32'd16777619;

   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_LOOKUP = 2'd1;
   localparam logic [1:0] FUNC_REMOVE = 2'd2;
   localparam logic [1:0] FUNC_UNDEF  = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_INVAL    = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;
   localparam logic [1:0] ST_POOLFULL = 2'd3;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] key;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] found_value;
      logic [6:0]  occupancy;
   } rsp_type;

   typedef struct packed {
      logic [1:0]          func;
      logic [31:0]         key;
      logic [31:0]         value;
      logic [BUCKET_W-1:0] bucket;
      logic                bad;
   } job_type;

   typedef enum logic [2:0] {
      B_IDLE, B_HEAD, B_CMP, B_HIT, B_FREE, B_MISS, B_ALLOC, B_DONE
   } back_state_type;

   function automatic logic is_null(input logic [LINK_W-1:0] link);
      return link >= NULL_LINK;
   endfunction

   // After reset the free list runs from the last slot down to slot zero.
   function automatic logic [LINK_W-1:0] reset_link(input logic [IDX_W-1:0] idx);
      logic [LINK_W-1:0] wide;
      wide = LINK_W'(idx);
      return (idx == '0) ? NULL_LINK : wide - LINK_W'(1);
   endfunction

endpackage

>>> rtl/cht_ram.sv
// ---------------------------------------------------------------------------
// cht_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module cht_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                    clock,
   input  logic                                    we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                        wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                        rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule

>>> rtl/cht_fifo.sv
// ---------------------------------------------------------------------------
// cht_fifo
// Short queue of classified jobs between the front and back parts.
// ---------------------------------------------------------------------------
module cht_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cht_pkg::job_type push_data,
   output logic             full,
   input  logic             pop,
   output cht_pkg::job_type pop_data,
   output logic             empty
);
   cht_pkg::job_type                 mem_ff [cht_pkg::QDEPTH];
   logic [cht_pkg::QPTR_W-1:0]       wr_ff, wr_in, rd_ff, rd_in;
   logic [cht_pkg::QPTR_W:0]         cnt_ff, cnt_in;
   logic                             do_push, do_pop;

   assign full     = cnt_ff == (cht_pkg::QPTR_W+1)'(cht_pkg::QDEPTH);
   assign empty    = cnt_ff == '0;
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? wr_ff + cht_pkg::QPTR_W'(1) : wr_ff;
      rd_in  = do_pop ? rd_ff + cht_pkg::QPTR_W'(1) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + (cht_pkg::QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - (cht_pkg::QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end
endmodule

>>> rtl/cht_front.sv
// ---------------------------------------------------------------------------
// cht_front
// Accepts requests, checks arguments and hashes the key with FNV-1a,
// one byte per cycle, then hands the job to the queue.
// ---------------------------------------------------------------------------
module cht_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cht_pkg::req_type req_data,
   output logic             push,
   output cht_pkg::job_type push_data,
   input  logic             full
);
   logic             busy_ff, busy_in, hashing_ff, hashing_in;
   logic [1:0]       byte_ff, byte_in;
   logic [31:0]      hash_ff, hash_in, mix;
   logic [31:0]      prod;
   logic [7:0]       kbyte;
   cht_pkg::job_type job_ff, job_in;
   logic             accept;

   assign req_stall = busy_ff;
   assign accept    = req_valid & ~busy_ff;
   assign kbyte     = job_ff.key[8*byte_ff +: 8];
   assign mix       = hash_ff ^ {24'd0, kbyte};
   assign prod      = mix * cht_pkg::FNV_MULT;
   assign push      = busy_ff & ~hashing_ff;

   always_comb begin
      push_data        = job_ff;
      push_data.bucket = hash_ff[cht_pkg::BUCKET_W-1:0];
   end

   always_comb begin
      busy_in    = busy_ff;
      hashing_in = hashing_ff;
      byte_in    = byte_ff;
      hash_in    = hash_ff;
      job_in     = job_ff;
      if (accept) begin
         busy_in      = 1'b1;
         hashing_in   = 1'b1;
         byte_in      = 2'd0;
         hash_in      = cht_pkg::FNV_BASIS;
         job_in.func  = req_data.func;
         job_in.key   = req_data.key;
         job_in.value = req_data.value;
         job_in.bucket = '0;
         job_in.bad   = (req_data.key == 32'd0) ||
                        (req_data.func != cht_pkg::FUNC_INSERT &&
                         req_data.func != cht_pkg::FUNC_LOOKUP &&
                         req_data.func != cht_pkg::FUNC_REMOVE) ||
                        (req_data.func == cht_pkg::FUNC_INSERT && req_data.value == 32'd0);
      end else if (hashing_ff) begin
         hash_in = prod;
         byte_in = byte_ff + 2'd1;
         if (byte_ff == 2'd3) begin
            hashing_in = 1'b0;
         end
      end else if (busy_ff && !full) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         hashing_ff <= 1'b0;
      end else begin
         busy_ff    <= busy_in;
         hashing_ff <= hashing_in;
      end
      byte_ff <= byte_in;
      hash_ff <= hash_in;
      job_ff  <= job_in;
   end
endmodule

>>> rtl/cht_back.sv
// ---------------------------------------------------------------------------
// cht_back
// Executes queued jobs: walks the bucket chain, updates the slot pool and
// the free list, and drives the result register.
// ---------------------------------------------------------------------------
module cht_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             empty,
   input  cht_pkg::job_type pop_data,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cht_pkg::rsp_type rsp_data
);
   localparam int BW = cht_pkg::BUCKET_W;
   localparam int IW = cht_pkg::IDX_W;
   localparam int LW = cht_pkg::LINK_W;

   cht_pkg::back_state_type state_ff, state_in;
   cht_pkg::job_type        job_ff, job_in;
   logic [LW-1:0]           cur_ff, cur_in, prev_ff, prev_in, head_ff, head_in;
   logic [LW-1:0]           nxt_ff, nxt_in, free_ff, free_in, count_ff, count_in;
   logic [31:0]             found_ff, found_in;
   logic [1:0]              status_ff, status_in;
   logic [cht_pkg::BUCKETS-1:0] head_vld_ff, head_vld_in;
   logic [cht_pkg::ENTRIES-1:0] link_vld_ff, link_vld_in;
   logic [IW-1:0]           link_ra_ff;
   logic                    rsp_valid_ff, rsp_valid_in, load_rsp;
   cht_pkg::rsp_type        rsp_data_ff, rsp_data_in;

   logic          head_we, key_we, val_we, link_we;
   logic [BW-1:0] head_waddr, head_raddr;
   logic [LW-1:0] head_wdata, head_rdata, link_wdata, link_rdata, link_rd, head_cur;
   logic [IW-1:0] slot_ra, key_waddr, val_waddr, link_waddr;
   logic [31:0]   key_wdata, val_wdata, key_rdata, val_rdata;

   cht_ram #(.WIDTH(LW), .DEPTH(cht_pkg::BUCKETS)) u_head (
      .clock, .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
      .raddr(head_raddr), .rdata(head_rdata));
   cht_ram #(.WIDTH(32), .DEPTH(cht_pkg::ENTRIES)) u_key (
      .clock, .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
      .raddr(slot_ra), .rdata(key_rdata));
   cht_ram #(.WIDTH(32), .DEPTH(cht_pkg::ENTRIES)) u_val (
      .clock, .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
      .raddr(slot_ra), .rdata(val_rdata));
   cht_ram #(.WIDTH(LW), .DEPTH(cht_pkg::ENTRIES)) u_link (
      .clock, .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
      .raddr(slot_ra), .rdata(link_rdata));

   // A link that was never written still holds its place in the reset free list.
   assign link_rd   = link_vld_ff[link_ra_ff] ? link_rdata : cht_pkg::reset_link(link_ra_ff);
   assign head_cur  = head_vld_ff[job_ff.bucket] ? head_rdata : cht_pkg::NULL_LINK;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in   = state_ff;
      job_in     = job_ff;
      cur_in     = cur_ff;
      prev_in    = prev_ff;
      head_in    = head_ff;
      nxt_in     = nxt_ff;
      free_in    = free_ff;
      count_in   = count_ff;
      found_in   = found_ff;
      status_in  = status_ff;
      pop        = 1'b0;
      load_rsp   = 1'b0;
      head_we    = 1'b0;
      key_we     = 1'b0;
      val_we     = 1'b0;
      link_we    = 1'b0;
      head_raddr = pop_data.bucket;
      head_waddr = job_ff.bucket;
      head_wdata = nxt_ff;
      key_waddr  = free_ff[IW-1:0];
      key_wdata  = job_ff.key;
      val_waddr  = cur_ff[IW-1:0];
      val_wdata  = job_ff.value;
      link_waddr = cur_ff[IW-1:0];
      link_wdata = free_ff;
      slot_ra    = '0;
      case (state_ff)
         cht_pkg::B_IDLE: begin
            if (!empty) begin
               pop      = 1'b1;
               job_in   = pop_data;
               found_in = 32'd0;
               if (pop_data.bad) begin
                  status_in = cht_pkg::ST_INVAL;
                  state_in  = cht_pkg::B_DONE;
               end else begin
                  state_in = cht_pkg::B_HEAD;
               end
            end
         end
         cht_pkg::B_HEAD: begin
            head_in = head_cur;
            cur_in  = head_cur;
            prev_in = cht_pkg::NULL_LINK;
            if (cht_pkg::is_null(head_cur)) begin
               state_in = cht_pkg::B_MISS;
            end else begin
               slot_ra  = head_cur[IW-1:0];
               state_in = cht_pkg::B_CMP;
            end
         end
         cht_pkg::B_CMP: begin
            if (key_rdata == job_ff.key) begin
               nxt_in   = link_rd;
               found_in = val_rdata;
               state_in = cht_pkg::B_HIT;
            end else begin
               prev_in = cur_ff;
               cur_in  = link_rd;
               if (cht_pkg::is_null(link_rd)) begin
                  state_in = cht_pkg::B_MISS;
               end else begin
                  slot_ra = link_rd[IW-1:0];
               end
            end
         end
         cht_pkg::B_HIT: begin
            status_in = cht_pkg::ST_OK;
            state_in  = cht_pkg::B_DONE;
            case (job_ff.func)
               cht_pkg::FUNC_INSERT: begin
                  val_we   = 1'b1;
                  found_in = 32'd0;
               end
               cht_pkg::FUNC_LOOKUP: begin
               end
               cht_pkg::FUNC_REMOVE: begin
                  found_in = 32'd0;
                  if (cht_pkg::is_null(prev_ff)) begin
                     head_we = 1'b1;
                  end else begin
                     link_we    = 1'b1;
                     link_waddr = prev_ff[IW-1:0];
                     link_wdata = nxt_ff;
                  end
                  state_in = cht_pkg::B_FREE;
               end
               default: begin
                  found_in  = 32'd0;
                  status_in = cht_pkg::ST_INVAL;
               end
            endcase
         end
         cht_pkg::B_FREE: begin
            link_we  = 1'b1;
            free_in  = cur_ff;
            count_in = count_ff - LW'(1);
            state_in = cht_pkg::B_DONE;
         end
         cht_pkg::B_MISS: begin
            found_in = 32'd0;
            state_in = cht_pkg::B_DONE;
            if (job_ff.func == cht_pkg::FUNC_INSERT) begin
               if (cht_pkg::is_null(free_ff)) begin
                  status_in = cht_pkg::ST_POOLFULL;
               end else begin
                  slot_ra  = free_ff[IW-1:0];
                  state_in = cht_pkg::B_ALLOC;
               end
            end else begin
               status_in = cht_pkg::ST_NOTFOUND;
            end
         end
         cht_pkg::B_ALLOC: begin
            key_we     = 1'b1;
            val_we     = 1'b1;
            val_waddr  = free_ff[IW-1:0];
            link_we    = 1'b1;
            link_waddr = free_ff[IW-1:0];
            link_wdata = head_ff;
            head_we    = 1'b1;
            head_wdata = free_ff;
            free_in    = link_rd;
            count_in   = count_ff + LW'(1);
            status_in  = cht_pkg::ST_OK;
            state_in   = cht_pkg::B_DONE;
         end
         cht_pkg::B_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               state_in = cht_pkg::B_IDLE;
            end
         end
         default: begin
            state_in = cht_pkg::B_IDLE;
         end
      endcase
   end

   always_comb begin
      head_vld_in = head_vld_ff;
      link_vld_in = link_vld_ff;
      if (head_we) begin
         head_vld_in[head_waddr] = 1'b1;
      end
      if (link_we) begin
         link_vld_in[link_waddr] = 1'b1;
      end
      rsp_valid_in = load_rsp | (rsp_valid_ff & rsp_stall);
      rsp_data_in  = rsp_data_ff;
      if (load_rsp) begin
         rsp_data_in.status      = status_ff;
         rsp_data_in.found_value = found_ff;
         rsp_data_in.occupancy   = 7'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cht_pkg::B_IDLE;
         free_ff      <= LW'(cht_pkg::ENTRIES - 1);
         count_ff     <= '0;
         head_vld_ff  <= '0;
         link_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_ff      <= free_in;
         count_ff     <= count_in;
         head_vld_ff  <= head_vld_in;
         link_vld_ff  <= link_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff      <= job_in;
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      head_ff     <= head_in;
      nxt_ff      <= nxt_in;
      found_ff    <= found_in;
      status_ff   <= status_in;
      link_ra_ff  <= slot_ra;
      rsp_data_ff <= rsp_data_in;
   end
endmodule

>>> rtl/chained_hash_table_engine.sv
// ---------------------------------------------------------------------------
// chained_hash_table_engine
// Key-value table with FNV-1a bucket hashing and chained slots from a pool.
//
//   Port group   Direction   Carries
//   req_*        in          func, key, value
//   rsp_*        out         status, found_value, occupancy
//
// The front hashes the four key bytes in turn, then hands the job off; the back
// reads the bucket head and walks the chain one entry at a time, with an extra
// step when an insert allocates a slot or a remove frees one.
// Reset empties every bucket and rebuilds the free list at once.
// A stalled result holds the back part; the queue lets the front go on.
// ---------------------------------------------------------------------------
module chained_hash_table_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cht_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cht_pkg::rsp_type rsp_data
);
   logic             push, full, pop, empty;
   cht_pkg::job_type push_data, pop_data;

   cht_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .push, .push_data, .full);

   cht_fifo u_fifo (
      .clock, .reset, .push, .push_data, .full, .pop, .pop_data, .empty);

   cht_back u_back (
      .clock, .reset, .empty, .pop_data, .pop, .rsp_valid, .rsp_stall, .rsp_data);
endmodule

>>> rtl/cht_checker.sv
// ---------------------------------------------------------------------------
// cht_checker
// Port-level checks on the result channel of the table engine.
// ---------------------------------------------------------------------------
module cht_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input cht_pkg::rsp_type rsp_data
);
   a_found_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != cht_pkg::ST_OK |-> rsp_data.found_value == 32'd0)
      else $error("found value set on a failed request");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.occupancy <= 7'(cht_pkg::ENTRIES))
      else $error("occupancy beyond pool size");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
endmodule

bind chained_hash_table_engine cht_checker u_cht_checker (
   .clock, .reset, .rsp_valid, .rsp_stall, .rsp_data);
